FILE: design/tgpi_pkg.sv
package tgpi_pkg;

  localparam logic [4:0] PosMax   = 5'd17;
  localparam logic [4:0] RotCount = 5'd24;
  localparam logic [4:0] ResMod   = 5'd9;

  localparam logic CmdProduct = 1'b0;
  localparam logic CmdInverse = 1'b1;

  typedef logic [3:0][1:0] perm_t;

  typedef struct packed {
    logic [4:0] pos;
    logic [1:0] pc;
    logic       a_ok;
    logic       b_ok;
  } lane_out_t;

  // residue of a position, valid for 0..17
  function automatic logic [3:0] mod9(logic [4:0] x);
    logic [4:0] t;
    t = (x > 5'd8) ? x - ResMod : x;
    return t[3:0];
  endfunction

  function automatic perm_t rot_decode(logic [4:0] r);
    logic [2:0] q;
    logic [2:0] q3;
    logic [3:0][1:0] dig;
    logic [3:0] used;
    perm_t p;
    logic [1:0] k;
    logic found;
    q = r[4:2];
    q3 = (q >= 3'd3) ? q - 3'd3 : q;
    dig[0] = r[1:0];
    dig[1] = q3[1:0];
    dig[2] = {1'b0, (q >= 3'd3)};
    dig[3] = 2'd0;
    used = '0;
    p = '0;
    p[0] = dig[0];
    used[dig[0]] = 1'b1;
    for (int i = 1; i < 4; i++) begin
      k = 2'd0;
      found = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if (!used[j] && !found) begin
          if (k == dig[i]) begin
            p[i] = 2'(j);
            found = 1'b1;
          end else begin
            k = k + 2'd1;
          end
        end
      end
      used[p[i]] = 1'b1;
    end
    return p;
  endfunction

  function automatic logic [4:0] rot_encode(perm_t p);
    logic [3:0] used;
    logic [2:0][1:0] dig;
    logic [1:0] rank;
    used = '0;
    dig = '0;
    for (int i = 0; i < 3; i++) begin
      rank = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if ((2'(j) < p[i]) && !used[j]) begin
          rank = rank + 2'd1;
        end
      end
      dig[i] = rank;
      used[p[i]] = 1'b1;
    end
    return {3'd0, dig[0]} + {1'b0, dig[1], 2'b00} + (dig[2][0] ? 5'd12 : 5'd0);
  endfunction

endpackage

FILE: design/tgpi_lane.sv
module tgpi_lane (
  input  logic                  cmd_i,
  input  logic [1:0]            lane_id_i,
  input  logic [4:0]            a_pos_i,
  input  logic [4:0]            b_pos_i,
  input  tgpi_pkg::perm_t       pa_i,
  input  tgpi_pkg::perm_t       pb_i,
  output tgpi_pkg::lane_out_t   lane_o
);

  logic [3:0] ra;
  logic [3:0] rb;
  logic [4:0] sum;
  logic [3:0] res;
  logic       ori;
  logic [1:0] inv_idx;

  assign ra  = tgpi_pkg::mod9(a_pos_i);
  assign rb  = tgpi_pkg::mod9(b_pos_i);
  assign sum = {1'b0, ra} + {1'b0, rb};

  // position of this lane's index in the permutation of a
  always_comb begin
    inv_idx = 2'd0;
    for (int j = 0; j < 4; j++) begin
      if (pa_i[j] == lane_id_i) begin
        inv_idx = 2'(j);
      end
    end
  end

  always_comb begin
    if (cmd_i == tgpi_pkg::CmdProduct) begin
      ori       = (a_pos_i > 5'd8) ^ (b_pos_i > 5'd8);
      res       = (sum >= tgpi_pkg::ResMod) ? 4'(sum - tgpi_pkg::ResMod) : sum[3:0];
      lane_o.pc = pb_i[pa_i[lane_id_i]];
    end else begin
      ori       = (a_pos_i > 5'd8);
      res       = (ra == 4'd0) ? 4'd0 : 4'(tgpi_pkg::ResMod - {1'b0, ra});
      lane_o.pc = inv_idx;
    end
    lane_o.pos  = (ori ? tgpi_pkg::ResMod : 5'd0) + {1'b0, res};
    lane_o.a_ok = (a_pos_i <= tgpi_pkg::PosMax);
    lane_o.b_ok = (b_pos_i <= tgpi_pkg::PosMax);
  end

endmodule

FILE: design/tgpi_merge.sv
module tgpi_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           cmd_i,
  input  logic                           a_rot_ok_i,
  input  logic                           b_rot_ok_i,
  input  tgpi_pkg::lane_out_t [3:0]      lanes_i,
  output logic                           valid_o,
  output logic [3:0][4:0]                pos_o,
  output logic [4:0]                     rot_o,
  output logic                           bad_o
);

  logic            ok;
  tgpi_pkg::perm_t pc;
  logic            valid_q;
  logic [3:0][4:0] pos_q, pos_d;
  logic [4:0]      rot_q, rot_d;
  logic            bad_q;

  always_comb begin
    ok = a_rot_ok_i && (b_rot_ok_i || cmd_i == tgpi_pkg::CmdInverse);
    for (int i = 0; i < 4; i++) begin
      ok    = ok && lanes_i[i].a_ok && (lanes_i[i].b_ok || cmd_i == tgpi_pkg::CmdInverse);
      pc[i] = lanes_i[i].pc;
    end
    for (int i = 0; i < 4; i++) begin
      pos_d[i] = ok ? lanes_i[i].pos : 5'd0;
    end
    rot_d = ok ? tgpi_pkg::rot_encode(pc) : 5'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pos_q <= pos_d;
      rot_q <= rot_d;
      bad_q <= !ok;
    end
  end

  assign valid_o = valid_q;
  assign pos_o   = pos_q;
  assign rot_o   = rot_q;
  assign bad_o   = bad_q;

endmodule

FILE: design/torus_group_product_inverse_core.sv
// the result of an accepted transaction is registered and appears in the next cycle
// throughput: one transaction per cycle, busy stays low
// four axis lanes run in parallel, one registered merge stage encodes the rotation
// the receiver cannot stall: the result is valid for exactly one cycle
// reset (rst_ni low, asynchronous) clears the result strobe only
module torus_group_product_inverse_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [4:0] a_pos0_i,
  input  logic [4:0] a_pos1_i,
  input  logic [4:0] a_pos2_i,
  input  logic [4:0] a_pos3_i,
  input  logic [4:0] a_rot_i,
  input  logic [4:0] b_pos0_i,
  input  logic [4:0] b_pos1_i,
  input  logic [4:0] b_pos2_i,
  input  logic [4:0] b_pos3_i,
  input  logic [4:0] b_rot_i,
  output logic       valid_o,
  output logic [4:0] r_pos0_o,
  output logic [4:0] r_pos1_o,
  output logic [4:0] r_pos2_o,
  output logic [4:0] r_pos3_o,
  output logic [4:0] r_rot_o,
  output logic       bad_input_o
);

  tgpi_pkg::perm_t           pa;
  tgpi_pkg::perm_t           pb;
  logic [3:0][4:0]           a_pos;
  logic [3:0][4:0]           b_pos;
  tgpi_pkg::lane_out_t [3:0] lanes;
  logic [3:0][4:0]           r_pos;

  assign busy  = 1'b0;
  assign pa    = tgpi_pkg::rot_decode(a_rot_i);
  assign pb    = tgpi_pkg::rot_decode(b_rot_i);
  assign a_pos = {a_pos3_i, a_pos2_i, a_pos1_i, a_pos0_i};
  assign b_pos = {b_pos3_i, b_pos2_i, b_pos1_i, b_pos0_i};

  for (genvar g = 0; g < 4; g++) begin : g_lane
    tgpi_lane u_lane (
      .cmd_i     (cmd_i),
      .lane_id_i (2'(g)),
      .a_pos_i   (a_pos[g]),
      .b_pos_i   (b_pos[g]),
      .pa_i      (pa),
      .pb_i      (pb),
      .lane_o    (lanes[g])
    );
  end

  tgpi_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (start && !busy),
    .cmd_i      (cmd_i),
    .a_rot_ok_i (a_rot_i < tgpi_pkg::RotCount),
    .b_rot_ok_i (b_rot_i < tgpi_pkg::RotCount),
    .lanes_i    (lanes),
    .valid_o    (valid_o),
    .pos_o      (r_pos),
    .rot_o      (r_rot_o),
    .bad_o      (bad_input_o)
  );

  assign r_pos0_o = r_pos[0];
  assign r_pos1_o = r_pos[1];
  assign r_pos2_o = r_pos[2];
  assign r_pos3_o = r_pos[3];

endmodule

FILE: design/tgpi_checker.sv
module tgpi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic [4:0] r_pos0_o,
  input logic [4:0] r_pos1_o,
  input logic [4:0] r_pos2_o,
  input logic [4:0] r_pos3_o,
  input logic [4:0] r_rot_o,
  input logic       bad_input_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("missing result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !valid_o)
    else $error("result without transaction");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_input_o) |-> (r_pos0_o == 5'd0 && r_pos1_o == 5'd0 &&
      r_pos2_o == 5'd0 && r_pos3_o == 5'd0 && r_rot_o == 5'd0))
    else $error("nonzero result on bad input");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !bad_input_o) |-> (r_pos0_o <= 5'd17 && r_pos1_o <= 5'd17 &&
      r_pos2_o <= 5'd17 && r_pos3_o <= 5'd17 && r_rot_o < 5'd24))
    else $error("result out of range");

endmodule

bind torus_group_product_inverse_core tgpi_checker u_tgpi_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchdogLimit = 1000;
  localparam int RandomPerPhase = 500;
  localparam logic CmdProduct = tgpi_pkg::CmdProduct;
  localparam logic CmdInverse = tgpi_pkg::CmdInverse;

  typedef logic [3:0][1:0] axis_map_t;

  typedef struct packed {
    logic            cmd;
    logic [3:0][4:0] a_pos;
    logic [4:0]      a_rot;
    logic [3:0][4:0] b_pos;
    logic [4:0]      b_rot;
  } group_op_t;

  typedef struct packed {
    logic [3:0][4:0] pos;
    logic [4:0]      rot;
    logic            bad;
  } group_res_t;

  typedef struct packed {
    group_op_t  op;
    logic       typed;
    group_res_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       valid_o;
  logic [4:0] r_pos0_o, r_pos1_o, r_pos2_o, r_pos3_o, r_rot_o;
  logic       bad_input_o;

  group_op_t  drv_op = '0;
  logic       drv_typed = 1'b0;
  group_res_t drv_res = '0;

  group_res_t pending_results[$];
  stim_row_t  stim_table[$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         n_product = 0;
  int         n_inverse = 0;
  int         n_flagged = 0;
  int         n_checked = 0;

  torus_group_product_inverse_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (drv_op.cmd),
    .a_pos0_i   (drv_op.a_pos[0]),
    .a_pos1_i   (drv_op.a_pos[1]),
    .a_pos2_i   (drv_op.a_pos[2]),
    .a_pos3_i   (drv_op.a_pos[3]),
    .a_rot_i    (drv_op.a_rot),
    .b_pos0_i   (drv_op.b_pos[0]),
    .b_pos1_i   (drv_op.b_pos[1]),
    .b_pos2_i   (drv_op.b_pos[2]),
    .b_pos3_i   (drv_op.b_pos[3]),
    .b_rot_i    (drv_op.b_rot),
    .valid_o    (valid_o),
    .r_pos0_o   (r_pos0_o),
    .r_pos1_o   (r_pos1_o),
    .r_pos2_o   (r_pos2_o),
    .r_pos3_o   (r_pos3_o),
    .r_rot_o    (r_rot_o),
    .bad_input_o(bad_input_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // rotation index -> permutation by mixed-radix digits
  function automatic axis_map_t map_of_rot(logic [4:0] r);
    int        dg[4];
    logic [3:0] taken;
    axis_map_t m;
    int        cnt;
    bit        found;
    dg[0] = r % 4;
    dg[1] = (r / 4) % 3;
    dg[2] = (r / 12) % 2;
    dg[3] = 0;
    taken = '0;
    m = '0;
    m[0] = 2'(dg[0]);
    taken[dg[0]] = 1'b1;
    for (int i = 1; i < 4; i++) begin
      cnt = 0;
      found = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if (!taken[j] && !found) begin
          if (cnt == dg[i]) begin
            m[i] = 2'(j);
            found = 1'b1;
          end else begin
            cnt++;
          end
        end
      end
      taken[m[i]] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [4:0] rot_of_map(axis_map_t m);
    logic [3:0] taken;
    int         dg[3];
    taken = '0;
    for (int i = 0; i < 3; i++) begin
      dg[i] = 0;
      for (int j = 0; j < int'(m[i]); j++) begin
        if (!taken[j]) dg[i]++;
      end
      taken[m[i]] = 1'b1;
    end
    return 5'(dg[0] + 4 * dg[1] + 12 * dg[2]);
  endfunction

  function automatic bit element_in_range(logic [3:0][4:0] p, logic [4:0] r);
    for (int i = 0; i < 4; i++) begin
      if (p[i] > tgpi_pkg::PosMax) return 1'b0;
    end
    return r < tgpi_pkg::RotCount;
  endfunction

  function automatic group_res_t torus_predict(group_op_t o);
    group_res_t e;
    axis_map_t  ma, mb, mc;
    int         x, y, ori, rsd;
    e = '0;
    if (!element_in_range(o.a_pos, o.a_rot) ||
        (o.cmd == CmdProduct && !element_in_range(o.b_pos, o.b_rot))) begin
      e.bad = 1'b1;
      return e;
    end
    ma = map_of_rot(o.a_rot);
    mb = map_of_rot(o.b_rot);
    mc = '0;
    for (int i = 0; i < 4; i++) begin
      x = o.a_pos[i];
      y = o.b_pos[i];
      if (o.cmd == CmdProduct) begin
        ori = int'(x > 8) ^ int'(y > 8);
        rsd = (x % 9 + y % 9) % 9;
        mc[i] = mb[ma[i]];
      end else begin
        ori = int'(x > 8);
        rsd = (9 - x % 9) % 9;
        mc[ma[i]] = 2'(i);
      end
      e.pos[i] = 5'(ori * 9 + rsd);
    end
    e.rot = rot_of_map(mc);
    return e;
  endfunction

  function automatic group_op_t op(logic c, int a0, int a1, int a2, int a3, int ar,
                                   int b0, int b1, int b2, int b3, int br);
    group_op_t o;
    o.cmd = c;
    o.a_pos = {5'(a3), 5'(a2), 5'(a1), 5'(a0)};
    o.a_rot = 5'(ar);
    o.b_pos = {5'(b3), 5'(b2), 5'(b1), 5'(b0)};
    o.b_rot = 5'(br);
    return o;
  endfunction

  function automatic group_res_t res(int p0, int p1, int p2, int p3, int r, logic bad);
    group_res_t e;
    e.pos = {5'(p3), 5'(p2), 5'(p1), 5'(p0)};
    e.rot = 5'(r);
    e.bad = bad;
    return e;
  endfunction

  // mostly valid elements, some with one field pushed out of range, some raw
  function automatic group_op_t random_op();
    group_op_t o;
    int        sel, k;
    o.cmd = 1'($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) begin
      o.a_pos[i] = 5'($urandom_range(0, 17));
      o.b_pos[i] = 5'($urandom_range(0, 17));
    end
    o.a_rot = 5'($urandom_range(0, 23));
    o.b_rot = 5'($urandom_range(0, 23));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      o = group_op_t'($urandom);
      o.b_rot = 5'($urandom);
    end else if (sel < 22) begin
      k = $urandom_range(0, 9);
      if (k < 4) o.a_pos[k] = 5'($urandom_range(18, 31));
      else if (k == 4) o.a_rot = 5'($urandom_range(24, 31));
      else if (k < 9) o.b_pos[k-5] = 5'($urandom_range(18, 31));
      else o.b_rot = 5'($urandom_range(24, 31));
    end
    return o;
  endfunction

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      drv_op = group_op_t'({$urandom, $urandom});
    end
  endtask

  task automatic send_op(group_op_t o, logic typed, group_res_t e);
    @(negedge clk_i);
    drv_op = o;
    drv_typed = typed;
    drv_res = e;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // each cycle is idle with a chance of gap_pct in a hundred
  task automatic random_phase(int n, int gap_pct);
    repeat (n) begin
      while ($urandom_range(0, 99) < gap_pct) idle_sender(1);
      send_op(random_op(), 1'b0, '0);
    end
  endtask

  // transaction check and watchdog
  always @(posedge clk_i) begin
    group_res_t want;
    group_res_t got;
    if (rst_ni) begin
      idle_cycles++;
      if (valid_o) begin
        idle_cycles = 0;
        got.pos = {r_pos3_o, r_pos2_o, r_pos1_o, r_pos0_o};
        got.rot = r_rot_o;
        got.bad = bad_input_o;
        if (pending_results.size() == 0) begin
          $error("result with no transaction pending");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          for (int i = 0; i < 4; i++) begin
            if (got.pos[i] !== want.pos[i]) begin
              $error("r_pos%0d: expected %0d, got %0d", i, want.pos[i], got.pos[i]);
              error_count++;
            end
          end
          if (got.rot !== want.rot) begin
            $error("r_rot: expected %0d, got %0d", want.rot, got.rot);
            error_count++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_input: expected %0d, got %0d", want.bad, got.bad);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        want = drv_typed ? drv_res : torus_predict(drv_op);
        pending_results.push_back(want);
        if (drv_op.cmd == CmdProduct) n_product++;
        else n_inverse++;
        if (want.bad) n_flagged++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;

    // identity, extremes, out-of-range per field, b ignored for inverse
    stim_table.push_back('{op(CmdProduct, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b0)});
    stim_table.push_back('{op(CmdInverse, 0, 0, 0, 0, 0, 31, 31, 31, 31, 31), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b0)});
    stim_table.push_back('{op(CmdProduct, 17, 17, 17, 17, 0, 17, 17, 17, 17, 0), 1'b1,
                           res(7, 7, 7, 7, 0, 1'b0)});
    stim_table.push_back('{op(CmdInverse, 9, 9, 9, 9, 23, 0, 0, 0, 0, 0), 1'b1,
                           res(9, 9, 9, 9, 23, 1'b0)});
    stim_table.push_back('{op(CmdProduct, 0, 0, 0, 0, 23, 0, 0, 0, 0, 23), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b0)});
    stim_table.push_back('{op(CmdProduct, 8, 8, 8, 8, 0, 1, 1, 1, 1, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b0)});
    stim_table.push_back('{op(CmdProduct, 18, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdProduct, 0, 0, 0, 0, 24, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdProduct, 5, 6, 7, 8, 3, 1, 2, 3, 31, 4), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdProduct, 5, 6, 7, 8, 3, 1, 2, 3, 4, 24), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdProduct, 17, 17, 17, 17, 23, 18, 18, 18, 18, 31), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdInverse, 0, 0, 31, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdInverse, 0, 0, 0, 18, 0, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdInverse, 0, 0, 0, 0, 31, 0, 0, 0, 0, 0), 1'b1,
                           res(0, 0, 0, 0, 0, 1'b1)});
    stim_table.push_back('{op(CmdInverse, 1, 8, 10, 17, 5, 24, 25, 30, 31, 31), 1'b0, '0});
    stim_table.push_back('{op(CmdProduct, 8, 9, 0, 17, 1, 9, 8, 17, 0, 22), 1'b0, '0});
    stim_table.push_back('{op(CmdProduct, 17, 16, 15, 14, 23, 1, 2, 3, 4, 12), 1'b0, '0});
    stim_table.push_back('{op(CmdProduct, 3, 12, 4, 13, 11, 6, 15, 7, 16, 17), 1'b0, '0});
    stim_table.push_back('{op(CmdInverse, 17, 0, 9, 8, 13, 17, 17, 17, 17, 23), 1'b0, '0});
    stim_table.push_back('{op(CmdInverse, 2, 11, 4, 15, 18, 0, 0, 0, 0, 0), 1'b0, '0});
    stim_table.push_back('{op(CmdProduct, 4, 13, 2, 11, 7, 14, 5, 16, 6, 19), 1'b0, '0});

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_table[i]) begin
      if ($urandom_range(0, 99) < 17) idle_sender($urandom_range(1, 3));
      send_op(stim_table[i].op, stim_table[i].typed, stim_table[i].res);
    end
    drain_results();

    random_phase(RandomPerPhase, 17);
    drain_results();
    random_phase(RandomPerPhase, 65);
    drain_results();
    random_phase(RandomPerPhase, 0);
    drain_results();
    repeat (4) @(negedge clk_i);

    if (pending_results.size() != 0) begin
      $error("%0d transactions never produced a result", pending_results.size());
      error_count++;
    end
    $display("covered %0d products and %0d inverses, %0d flagged out of range",
             n_product, n_inverse, n_flagged);
    $display("%0d results compared, %0d errors", n_checked, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tgpi_pkg.sv
design/tgpi_lane.sv
design/tgpi_merge.sv
design/torus_group_product_inverse_core.sv
design/tgpi_checker.sv
tb/tb_top.sv
